[src/ptsd_pkg.sv]
// ----------------------------------------------------------------------------
// Point-to-segment distance: shared definitions
// Codes for the nearest part of the segment and the configuration map.
// ----------------------------------------------------------------------------
package ptsd_pkg;

  // Which part of the segment lies nearest to the query point.
  typedef enum logic [1:0] {
    PART_INTERIOR   = 2'd0,
    PART_END_A      = 2'd1,
    PART_END_B      = 2'd2,
    PART_DEGENERATE = 2'd3
  } part_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_END_A_X = 3'd0,
    REG_END_A_Y = 3'd1,
    REG_END_A_Z = 3'd2,
    REG_END_B_X = 3'd3,
    REG_END_B_Y = 3'd4,
    REG_END_B_Z = 3'd5
  } cfg_reg_t;

  localparam int CFG_INDEX_BITS = 3;

endpackage

[src/point_to_segment_distance_core.sv]
// ----------------------------------------------------------------------------
// Point-to-segment distance core
// Euclidean distance from a 3D query point to a configured segment.
// ----------------------------------------------------------------------------
// The core accepts one query point per clock while full is low and returns one
// result per point in order, so a steady stream runs at one beat per cycle while
// the consumer keeps popping. A point passes through the front pipeline
// (differences, products, dot products, classification and the squared cross
// product), the four-entry queue behind it, the bit-per-stage square root and
// the four-entry result queue. Each stage holds one multiplier bank or one
// wide add and compare. The user must write endpoints through the configuration
// port only while no query is in flight; the core itself does not enforce this.
// The distance is truncated toward zero and saturates at its all-ones value.
module point_to_segment_distance_core #(
  parameter int COORD_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [COORD_BITS-1:0]            point_x,
  input  logic signed [COORD_BITS-1:0]            point_y,
  input  logic signed [COORD_BITS-1:0]            point_z,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [COORD_BITS:0]                     distance,
  output logic [1:0]                              nearest_part,
  input  logic                                    cfg_write,
  input  logic [ptsd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                   cfg_data
);
  import ptsd_pkg::*;

  localparam int MAG_W    = 2 * COORD_BITS + 2;
  localparam int NUM_W    = 4 * COORD_BITS + 4;
  localparam int RB       = COORD_BITS + 1;
  localparam int MQ_W     = 2 + MAG_W + NUM_W;
  localparam int OQ_W     = 2 + RB;
  localparam int Q_DEPTH  = 4;

  logic signed [COORD_BITS-1:0] end_a_x, end_a_y, end_a_z;
  logic signed [COORD_BITS-1:0] end_b_x, end_b_y, end_b_z;

  logic             front_in_valid;
  logic             front_valid;
  logic [NUM_W-1:0] front_num;
  logic [MAG_W-1:0] front_den;
  part_t            front_part;

  logic             mq_wr, mq_rd, mq_full, mq_empty;
  logic [MQ_W-1:0]  mq_rd_data;

  logic             root_ready;
  logic             root_valid;
  logic [RB-1:0]    root_dist;
  part_t            root_part;

  logic             oq_wr, oq_rd, oq_full;
  logic [OQ_W-1:0]  oq_rd_data;

  // Endpoint registers; writes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_a_x <= '0;
      end_a_y <= '0;
      end_a_z <= '0;
      end_b_x <= '0;
      end_b_y <= '0;
      end_b_z <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_END_A_X: end_a_x <= cfg_data;
        REG_END_A_Y: end_a_y <= cfg_data;
        REG_END_A_Z: end_a_z <= cfg_data;
        REG_END_B_X: end_b_x <= cfg_data;
        REG_END_B_Y: end_b_y <= cfg_data;
        REG_END_B_Z: end_b_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: classification and ratio set-up.
  assign front_in_valid = push && !full;

  ptsd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_in_valid),
    .in_full   (full),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .end_a_x   (end_a_x),
    .end_a_y   (end_a_y),
    .end_a_z   (end_a_z),
    .end_b_x   (end_b_x),
    .end_b_y   (end_b_y),
    .end_b_z   (end_b_z),
    .out_valid (front_valid),
    .out_ready (!mq_full),
    .out_num   (front_num),
    .out_den   (front_den),
    .out_part  (front_part)
  );

  // Queue between front and back.
  assign mq_wr = front_valid && !mq_full;
  assign mq_rd = root_ready && !mq_empty;

  ptsd_fifo #(
    .WIDTH (MQ_W),
    .DEPTH (Q_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mq_wr),
    .wr_data ({front_part, front_den, front_num}),
    .full    (mq_full),
    .rd_en   (mq_rd),
    .rd_data (mq_rd_data),
    .empty   (mq_empty)
  );

  // Back end: square root of the ratio.
  ptsd_root #(
    .COORD_BITS (COORD_BITS)
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mq_empty),
    .in_ready  (root_ready),
    .in_num    (mq_rd_data[NUM_W-1:0]),
    .in_den    (mq_rd_data[NUM_W+MAG_W-1:NUM_W]),
    .in_part   (part_t'(mq_rd_data[MQ_W-1:NUM_W+MAG_W])),
    .out_valid (root_valid),
    .out_ready (!oq_full),
    .out_dist  (root_dist),
    .out_part  (root_part)
  );

  // Result queue facing the consumer.
  assign oq_wr = root_valid && !oq_full;
  assign oq_rd = pop && !empty;

  ptsd_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (Q_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_wr),
    .wr_data ({root_part, root_dist}),
    .full    (oq_full),
    .rd_en   (oq_rd),
    .rd_data (oq_rd_data),
    .empty   (empty)
  );

  assign distance     = oq_rd_data[RB-1:0];
  assign nearest_part = oq_rd_data[OQ_W-1:RB];

  // The core comes out of reset empty and ready to take a beat.
  a_reset_state: assert property (@(posedge clk) (!rst && $past(rst)) |-> (empty && !full))
    else $error("core not empty and ready after reset");

  // Neither internal queue is written while it is full.
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mq_full |-> !mq_wr)
    else $error("middle queue written while full");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    oq_full |-> !oq_wr)
    else $error("result queue written while full");

endmodule

[src/ptsd_fifo.sv]
// ----------------------------------------------------------------------------
// Point-to-segment distance: small synchronous queue
// Count-based first-in first-out buffer with registered full and empty.
// ----------------------------------------------------------------------------
module ptsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  // Occupancy follows every write and read beat.
  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + CW'(1);
    end else if (!wr_en && rd_en) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      full   <= 1'b0;
      empty  <= 1'b1;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
      full  <= (count_next == CW'(DEPTH));
      empty <= (count_next == CW'(0));
    end
  end

  // Entry storage; no reset needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = store[rd_ptr];

endmodule

[src/ptsd_front.sv]
// ----------------------------------------------------------------------------
// Point-to-segment distance: front end
// Six-stage pipeline that forms the difference vectors, the dot products and
// the squared cross-product magnitude, classifies the nearest part and hands
// a numerator and denominator for the square-root stage onwards.
// ----------------------------------------------------------------------------
module ptsd_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_full,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic signed [COORD_BITS-1:0]  point_z,
  input  logic signed [COORD_BITS-1:0]  end_a_x,
  input  logic signed [COORD_BITS-1:0]  end_a_y,
  input  logic signed [COORD_BITS-1:0]  end_a_z,
  input  logic signed [COORD_BITS-1:0]  end_b_x,
  input  logic signed [COORD_BITS-1:0]  end_b_y,
  input  logic signed [COORD_BITS-1:0]  end_b_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4*COORD_BITS+3:0]       out_num,
  output logic [2*COORD_BITS+1:0]       out_den,
  output ptsd_pkg::part_t               out_part
);
  import ptsd_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS + 2;
  localparam int DOT_W  = 2 * COORD_BITS + 3;
  localparam int MAG_W  = 2 * COORD_BITS + 2;
  localparam int HALF   = COORD_BITS + 1;
  localparam int PP_W   = 2 * HALF;
  localparam int NUM_W  = 4 * COORD_BITS + 4;

  logic adv;
  logic v1, v2, v3, v4, v5, v6;

  // Stage 1: difference vectors.
  logic signed [DIFF_W-1:0] s1_da [3];
  logic signed [DIFF_W-1:0] s1_db [3];
  logic signed [DIFF_W-1:0] s1_d  [3];

  // Stage 2: element products.
  logic signed [PROD_W-1:0] s2_aa [3];
  logic signed [PROD_W-1:0] s2_bb [3];
  logic signed [PROD_W-1:0] s2_dd [3];
  logic signed [PROD_W-1:0] s2_ad [3];
  logic signed [PROD_W-1:0] s2_bd [3];

  // Stage 3: dot products.
  logic signed [DOT_W-1:0] s3_daa, s3_dbb, s3_len2, s3_ta, s3_tb;

  // Stage 4: classification and partial products.
  logic [MAG_W-1:0] s4_daa, s4_dbb, s4_len2;
  logic [PP_W-1:0]  s4_p1_ll, s4_p1_lh, s4_p1_hl, s4_p1_hh;
  logic [PP_W-1:0]  s4_p2_ll, s4_p2_lh, s4_p2_hh;
  part_t            s4_part;

  // Stage 5: full products.
  logic [NUM_W-1:0] s5_p1, s5_p2;
  logic [MAG_W-1:0] s5_daa, s5_dbb, s5_len2;
  part_t            s5_part;

  logic [MAG_W-1:0] s4_mag_next;

  // The whole front moves together; it holds while its last item waits.
  assign adv       = !v6 || out_ready;
  assign in_full   = !adv;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Stage 1: P-A, P-B and B-A.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_da[0] <= DIFF_W'(point_x) - DIFF_W'(end_a_x);
      s1_da[1] <= DIFF_W'(point_y) - DIFF_W'(end_a_y);
      s1_da[2] <= DIFF_W'(point_z) - DIFF_W'(end_a_z);
      s1_db[0] <= DIFF_W'(point_x) - DIFF_W'(end_b_x);
      s1_db[1] <= DIFF_W'(point_y) - DIFF_W'(end_b_y);
      s1_db[2] <= DIFF_W'(point_z) - DIFF_W'(end_b_z);
      s1_d[0]  <= DIFF_W'(end_b_x) - DIFF_W'(end_a_x);
      s1_d[1]  <= DIFF_W'(end_b_y) - DIFF_W'(end_a_y);
      s1_d[2]  <= DIFF_W'(end_b_z) - DIFF_W'(end_a_z);
    end
  end

  // Stage 2: one product per element and per dot product.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_aa[i] <= PROD_W'(s1_da[i]) * PROD_W'(s1_da[i]);
        s2_bb[i] <= PROD_W'(s1_db[i]) * PROD_W'(s1_db[i]);
        s2_dd[i] <= PROD_W'(s1_d[i])  * PROD_W'(s1_d[i]);
        s2_ad[i] <= PROD_W'(s1_da[i]) * PROD_W'(s1_d[i]);
        s2_bd[i] <= PROD_W'(s1_db[i]) * PROD_W'(s1_d[i]);
      end
    end
  end

  // Stage 3: sums of three products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_daa  <= DOT_W'(s2_aa[0]) + DOT_W'(s2_aa[1]) + DOT_W'(s2_aa[2]);
      s3_dbb  <= DOT_W'(s2_bb[0]) + DOT_W'(s2_bb[1]) + DOT_W'(s2_bb[2]);
      s3_len2 <= DOT_W'(s2_dd[0]) + DOT_W'(s2_dd[1]) + DOT_W'(s2_dd[2]);
      s3_ta   <= DOT_W'(s2_ad[0]) + DOT_W'(s2_ad[1]) + DOT_W'(s2_ad[2]);
      s3_tb   <= DOT_W'(s2_bd[0]) + DOT_W'(s2_bd[1]) + DOT_W'(s2_bd[2]);
    end
  end

  // Magnitude of the projection onto the segment.
  assign s4_mag_next = s3_ta[DOT_W-1] ? MAG_W'(-s3_ta) : MAG_W'(s3_ta);

  // Stage 4: classify, and split len2*daa and ta*ta into half-width products.
  // The squared cross product follows from |da|^2 |d|^2 - (da.d)^2.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_daa    <= s3_daa[MAG_W-1:0];
      s4_dbb    <= s3_dbb[MAG_W-1:0];
      s4_len2   <= s3_len2[MAG_W-1:0];
      s4_p1_ll  <= PP_W'(s3_len2[HALF-1:0])     * PP_W'(s3_daa[HALF-1:0]);
      s4_p1_lh  <= PP_W'(s3_len2[HALF-1:0])     * PP_W'(s3_daa[MAG_W-1:HALF]);
      s4_p1_hl  <= PP_W'(s3_len2[MAG_W-1:HALF]) * PP_W'(s3_daa[HALF-1:0]);
      s4_p1_hh  <= PP_W'(s3_len2[MAG_W-1:HALF]) * PP_W'(s3_daa[MAG_W-1:HALF]);
      s4_p2_ll  <= PP_W'(s4_mag_next[HALF-1:0]) * PP_W'(s4_mag_next[HALF-1:0]);
      s4_p2_lh  <= PP_W'(s4_mag_next[HALF-1:0]) * PP_W'(s4_mag_next[MAG_W-1:HALF]);
      s4_p2_hh  <= PP_W'(s4_mag_next[MAG_W-1:HALF]) * PP_W'(s4_mag_next[MAG_W-1:HALF]);
      if (s3_len2 == '0) begin
        s4_part <= PART_DEGENERATE;
      end else if (s3_ta[DOT_W-1]) begin
        s4_part <= PART_END_A;
      end else if (!s3_tb[DOT_W-1] && (s3_tb != '0)) begin
        s4_part <= PART_END_B;
      end else begin
        s4_part <= PART_INTERIOR;
      end
    end
  end

  // Stage 5: assemble the two full products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_p1   <= NUM_W'({s4_p1_hh, s4_p1_ll})
               + ((NUM_W'(s4_p1_lh) + NUM_W'(s4_p1_hl)) << HALF);
      s5_p2   <= NUM_W'({s4_p2_hh, s4_p2_ll})
               + (NUM_W'(s4_p2_lh) << (HALF + 1));
      s5_daa  <= s4_daa;
      s5_dbb  <= s4_dbb;
      s5_len2 <= s4_len2;
      s5_part <= s4_part;
    end
  end

  // Stage 6: choose the ratio whose root is the distance.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_part <= s5_part;
      case (s5_part)
        PART_END_B: begin
          out_num <= NUM_W'(s5_dbb);
          out_den <= MAG_W'(1);
        end
        PART_INTERIOR: begin
          out_num <= s5_p1 - s5_p2;
          out_den <= s5_len2;
        end
        default: begin
          out_num <= NUM_W'(s5_daa);
          out_den <= MAG_W'(1);
        end
      endcase
    end
  end

endmodule

[src/ptsd_root.sv]
// ----------------------------------------------------------------------------
// Point-to-segment distance: square-root back end
// Pipelined restoring root of num/den, one result bit per stage, giving the
// largest h below the saturation limit with h*h*den <= num.
// ----------------------------------------------------------------------------
module ptsd_root #(
  parameter int COORD_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [4*COORD_BITS+3:0]    in_num,
  input  logic [2*COORD_BITS+1:0]    in_den,
  input  ptsd_pkg::part_t            in_part,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COORD_BITS:0]        out_dist,
  output ptsd_pkg::part_t            out_part
);
  import ptsd_pkg::*;

  localparam int RB    = COORD_BITS + 1;
  localparam int MAG_W = 2 * COORD_BITS + 2;
  localparam int NUM_W = 4 * COORD_BITS + 4;
  localparam int YW    = MAG_W + RB;

  logic adv;

  // Per stage: remaining numerator, h*den, partial root, denominator.
  logic             v_q   [RB+1];
  logic [NUM_W-1:0] r_q   [RB+1];
  logic [YW-1:0]    y_q   [RB+1];
  logic [RB-1:0]    h_q   [RB+1];
  logic [MAG_W-1:0] den_q [RB+1];
  part_t            part_q[RB+1];

  assign adv       = !v_q[RB] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_q[RB];
  assign out_dist  = h_q[RB];
  assign out_part  = part_q[RB];

  // Valid bits move with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= RB; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_valid;
      for (int i = 0; i < RB; i++) begin
        v_q[i+1] <= v_q[i];
      end
    end
  end

  // Entry stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      r_q[0]    <= in_num;
      y_q[0]    <= '0;
      h_q[0]    <= '0;
      den_q[0]  <= in_den;
      part_q[0] <= in_part;
    end
  end

  // One stage per result bit, most significant first.
  for (genvar i = 0; i < RB; i++) begin : g_bit
    localparam int K = RB - 1 - i;
    logic [NUM_W-1:0] trial;
    logic             take;

    // (h + 2^K)^2 * den - h^2 * den = (h*den) * 2^(K+1) + den * 2^(2K)
    assign trial = (NUM_W'(y_q[i]) << (K + 1)) + (NUM_W'(den_q[i]) << (2 * K));
    assign take  = (trial <= r_q[i]);

    always_ff @(posedge clk) begin
      if (adv) begin
        r_q[i+1]    <= take ? (r_q[i] - trial) : r_q[i];
        y_q[i+1]    <= take ? (y_q[i] + (YW'(den_q[i]) << K)) : y_q[i];
        h_q[i+1]    <= h_q[i] | (RB'(take) << K);
        den_q[i+1]  <= den_q[i];
        part_q[i+1] <= part_q[i];
      end
    end
  end

endmodule
